// ----- hdl/hyphen_break_classifier_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the hyphen break classifier
// Concurrent checks, removed in synthesis builds
// ----------------------------------------------------------------------------
`ifndef HYPHEN_BREAK_CLASSIFIER_TOP_ASSERT_SVH
`define HYPHEN_BREAK_CLASSIFIER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// property that must hold on every clock edge outside reset
`define HBC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("hbc assertion failed");

// consequent must hold in the cycle after the antecedent
`define HBC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("hbc assertion failed");

`else

`define HBC_ASSERT(lbl, clk, rstn, prop)
`define HBC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- hdl/hbc_pkg.sv -----
// ----------------------------------------------------------------------------
// hbc_pkg
// Types, codepoint constants and script tests of the hyphen break classifier
// ----------------------------------------------------------------------------
package hbc_pkg;

  // field widths
  localparam int unsigned CP_W   = 21;
  localparam int unsigned LEN_W  = 8;
  localparam int unsigned POS_W  = 8;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned LOC_W  = 3;
  localparam int unsigned MIN_W  = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;

  // default longest word before the position saturates
  localparam int unsigned HBC_MAX_WORD_LEN_DEF = 255;

  // codepoints used by the rules
  localparam logic [CP_W-1:0] CP_HYPHEN_MINUS = 21'h00002D;
  localparam logic [CP_W-1:0] CP_SOFT_HYPHEN  = 21'h0000AD;
  localparam logic [CP_W-1:0] CP_MIDDLE_DOT   = 21'h0000B7;
  localparam logic [CP_W-1:0] CP_HYPHEN       = 21'h002010;
  localparam logic [CP_W-1:0] CP_LOWER_L      = 21'h00006C;
  localparam logic [CP_W-1:0] CP_UPPER_L      = 21'h00004C;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE        = 3'd0,
    KIND_BREAK       = 3'd1,
    KIND_NO_INSERT   = 3'd2,
    KIND_REPLACE     = 3'd3,
    KIND_INSERT_NEXT = 3'd4
  } break_kind_e;

  typedef enum logic [LOC_W-1:0] {
    LOC_OTHER      = 3'd0,
    LOC_CATALAN    = 3'd1,
    LOC_POLISH     = 3'd2,
    LOC_SLOVENIAN  = 3'd3,
    LOC_PORTUGUESE = 3'd4
  } locale_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOCALE     = 2'd0,
    CFG_MIN_PREFIX = 2'd1,
    CFG_MIN_SUFFIX = 2'd2
  } cfg_idx_e;

  // configuration registers as seen by the classifier
  typedef struct packed {
    logic [LOC_W-1:0] locale_kind;
    logic [MIN_W-1:0] min_prefix;
    logic [MIN_W-1:0] min_suffix;
  } hbc_cfg_t;

  // character window captured with each transaction
  typedef struct packed {
    logic [CP_W-1:0]  cur;
    logic [LEN_W-1:0] len;
    logic [POS_W-1:0] pos;
    logic [CP_W-1:0]  prev;
    logic [CP_W-1:0]  pprev;
  } hbc_win_t;

  function automatic logic in_span(logic [CP_W-1:0] c, logic [CP_W-1:0] lo,
                                   logic [CP_W-1:0] hi);
    return (c >= lo) && (c <= hi);
  endfunction

  // hyphens that allow a line break after them
  function automatic logic is_breaking_hyphen(logic [CP_W-1:0] c);
    return (c == CP_HYPHEN_MINUS) || (c == 21'h00058A) || (c == 21'h0005BE) ||
           (c == 21'h001400) || (c == CP_HYPHEN) || (c == 21'h002013) ||
           (c == 21'h002027) || (c == 21'h002E17) || (c == 21'h002E40);
  endfunction

  function automatic logic is_latin(logic [CP_W-1:0] c);
    return in_span(c, 21'h41, 21'h5A) || in_span(c, 21'h61, 21'h7A) ||
           in_span(c, 21'hC0, 21'h24F);
  endfunction

  function automatic logic is_arabic(logic [CP_W-1:0] c);
    return in_span(c, 21'h0600, 21'h06FF) || in_span(c, 21'h0750, 21'h077F);
  endfunction

  // telugu, kannada, malayalam and tamil
  function automatic logic is_dravidian(logic [CP_W-1:0] c);
    return in_span(c, 21'h0C00, 21'h0D7F) || in_span(c, 21'h0B80, 21'h0BFF);
  endfunction

endpackage

// ----- hdl/hbc_in_if.sv -----
// ----------------------------------------------------------------------------
// hbc_in_if
// Input channel: one codepoint of a word per transaction
// ----------------------------------------------------------------------------
interface hbc_in_if
  import hbc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CP_W-1:0]  codepoint;
  logic             word_start;
  logic [LEN_W-1:0] word_length;

  modport source (output valid, codepoint, word_start, word_length, input ready);
  modport sink   (input valid, codepoint, word_start, word_length, output ready);
endinterface

// ----- hdl/hbc_out_if.sv -----
// ----------------------------------------------------------------------------
// hbc_out_if
// Output channel: break kind and position of one character per transaction
// ----------------------------------------------------------------------------
interface hbc_out_if
  import hbc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] break_kind;
  logic [POS_W-1:0]  char_position;

  modport source (output valid, break_kind, char_position, input ready);
  modport sink   (input valid, break_kind, char_position, output ready);
endinterface

// ----- hdl/hbc_window.sv -----
// ----------------------------------------------------------------------------
// hbc_window
// Keeps the two previous codepoints and the word position, and registers
// the window of each accepted character for the classifier stage
// ----------------------------------------------------------------------------
`include "hyphen_break_classifier_top_assert.svh"

module hbc_window
  import hbc_pkg::*;
#(
  parameter int unsigned MAX_WORD_LEN = HBC_MAX_WORD_LEN_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hbc_in_if.sink     in_i,
  input  logic       win_ready_i,
  output logic       win_valid_o,
  output hbc_win_t   win_o
);

  // position saturates at the smaller of the word limit and the field range
  localparam logic [POS_W-1:0] POS_CAP =
    POS_W'((MAX_WORD_LEN < 255) ? MAX_WORD_LEN : 255);

  logic             acc;
  logic [POS_W-1:0] pos_now;
  logic [CP_W-1:0]  pprev_now;

  logic [CP_W-1:0]  prev_q, prev_d;
  logic [CP_W-1:0]  pprev_q, pprev_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             win_v_q;
  hbc_win_t         win_q, win_d;

  // stage can take a transaction when empty or draining
  assign in_i.ready = !win_v_q || win_ready_i;
  assign acc        = in_i.valid && in_i.ready;

  // word start restarts the position and drops the older character
  assign pos_now   = in_i.word_start ? '0 : pos_q;
  assign pprev_now = in_i.word_start ? '0 : pprev_q;

  always_comb begin
    win_d.cur   = in_i.codepoint;
    win_d.len   = in_i.word_length;
    win_d.pos   = pos_now;
    win_d.prev  = prev_q;
    win_d.pprev = pprev_now;
    prev_d      = in_i.codepoint;
    pprev_d     = in_i.word_start ? '0 : prev_q;
    pos_d       = (pos_now < POS_CAP) ? pos_now + POS_W'(1) : pos_now;
  end

  // history state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      pprev_q <= '0;
      pos_q   <= '0;
      win_v_q <= 1'b0;
    end else begin
      if (acc) begin
        prev_q  <= prev_d;
        pprev_q <= pprev_d;
        pos_q   <= pos_d;
      end
      if (acc) begin
        win_v_q <= 1'b1;
      end else if (win_ready_i) begin
        win_v_q <= 1'b0;
      end
    end
  end

  // window register
  always_ff @(posedge clk_i) begin
    if (acc) begin
      win_q <= win_d;
    end
  end

  assign win_valid_o = win_v_q;
  assign win_o       = win_q;

  `HBC_ASSERT(a_pos_capped, clk_i, rst_ni, pos_q <= POS_CAP)
  `HBC_ASSERT_NEXT(a_start_pos_zero, clk_i, rst_ni, acc && in_i.word_start,
                   (win_q.pos == '0) && (pos_q == POS_W'(1)))
  `HBC_ASSERT_NEXT(a_pprev_shift, clk_i, rst_ni, acc && !in_i.word_start,
                   pprev_q == $past(prev_q))
  `HBC_ASSERT_NEXT(a_pos_count, clk_i, rst_ni,
                   acc && !in_i.word_start && (pos_q < POS_CAP),
                   pos_q == POS_W'($past(pos_q) + POS_W'(1)))

endmodule

// ----- hdl/hbc_classify.sv -----
// ----------------------------------------------------------------------------
// hbc_classify
// Break kind rules on the registered window, result held in the output
// register until the transaction is taken
// ----------------------------------------------------------------------------
module hbc_classify
  import hbc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      win_valid_i,
  input  hbc_win_t  win_i,
  input  hbc_cfg_t  cfg_i,
  output logic      win_ready_o,
  hbc_out_if.source out_o
);

  logic             take;
  logic             past_two;
  logic             pl_sl;
  logic             hy_insert;
  logic             ll_pair;
  logic             prefix_ok;
  logic             suffix_ok;
  break_kind_e      kind_d;

  logic             out_v_q;
  break_kind_e      kind_q;
  logic [POS_W-1:0] pos_q;

  assign win_ready_o = !out_v_q || out_o.ready;
  assign take        = win_valid_i && win_ready_o;

  // rule conditions
  assign past_two  = |win_i.pos[POS_W-1:1];
  assign pl_sl     = (cfg_i.locale_kind == LOC_POLISH) ||
                     (cfg_i.locale_kind == LOC_SLOVENIAN);
  assign hy_insert = ((win_i.prev == CP_HYPHEN_MINUS) || (win_i.prev == CP_HYPHEN)) &&
                     pl_sl && (win_i.pos < win_i.len) && is_latin(win_i.cur);
  assign ll_pair   = ((win_i.pprev == CP_LOWER_L) && (win_i.cur == CP_LOWER_L)) ||
                     ((win_i.pprev == CP_UPPER_L) && (win_i.cur == CP_UPPER_L));
  assign prefix_ok = {{(POS_W-MIN_W){1'b0}}, cfg_i.min_prefix} < win_i.pos;
  // suffix test one bit wider so the sum never wraps
  assign suffix_ok = ({1'b0, win_i.pos} + {{(POS_W+1-MIN_W){1'b0}}, cfg_i.min_suffix})
                     <= {1'b0, win_i.len};

  // first rule that applies wins
  always_comb begin
    priority if (win_i.pos == '0) begin
      kind_d = KIND_NONE;
    end else if (past_two && is_breaking_hyphen(win_i.prev)) begin
      kind_d = hy_insert ? KIND_INSERT_NEXT : KIND_NO_INSERT;
    end else if (past_two && (win_i.prev == CP_SOFT_HYPHEN)) begin
      if (is_arabic(win_i.cur)) begin
        kind_d = KIND_INSERT_NEXT;
      end else if (is_dravidian(win_i.cur)) begin
        kind_d = KIND_NO_INSERT;
      end else begin
        kind_d = KIND_BREAK;
      end
    end else if ((win_i.prev == CP_MIDDLE_DOT) && past_two && prefix_ok && suffix_ok &&
                 (cfg_i.locale_kind == LOC_CATALAN) && ll_pair) begin
      kind_d = KIND_REPLACE;
    end else begin
      kind_d = KIND_NONE;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (take) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (take) begin
      kind_q <= kind_d;
      pos_q  <= win_i.pos;
    end
  end

  assign out_o.valid         = out_v_q;
  assign out_o.break_kind    = kind_q;
  assign out_o.char_position = pos_q;

endmodule

// ----- hdl/hyphen_break_classifier_top.sv -----
// The window register loads when an input transaction is accepted, and the
// result register loads from it when the classifier stage takes the window.
// Throughput: one codepoint per cycle unless the output stalls; the window and
// result registers each hold one transaction and advance together under ready.
// Reset clears the character history, the word position and both valid bits,
// and sets locale_kind to 0, min_prefix to 2 and min_suffix to 2.
// ----------------------------------------------------------------------------
// hyphen_break_classifier_top
// Break kind of each character of a word from a two-character window
// ----------------------------------------------------------------------------
module hyphen_break_classifier_top
  import hbc_pkg::*;
#(
  parameter int unsigned MAX_WORD_LEN = HBC_MAX_WORD_LEN_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  hbc_in_if.sink                in_i,
  hbc_out_if.source             out_o
);

  hbc_cfg_t cfg_q;
  logic     win_valid;
  logic     win_ready;
  hbc_win_t win;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.locale_kind <= LOC_OTHER;
      cfg_q.min_prefix  <= MIN_W'(2);
      cfg_q.min_suffix  <= MIN_W'(2);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LOCALE:     cfg_q.locale_kind <= cfg_data_i[LOC_W-1:0];
        CFG_MIN_PREFIX: cfg_q.min_prefix  <= cfg_data_i[MIN_W-1:0];
        CFG_MIN_SUFFIX: cfg_q.min_suffix  <= cfg_data_i[MIN_W-1:0];
        default: ;
      endcase
    end
  end

  // history and window stage
  hbc_window #(
    .MAX_WORD_LEN (MAX_WORD_LEN)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .win_ready_i (win_ready),
    .win_valid_o (win_valid),
    .win_o       (win)
  );

  // rules and result stage
  hbc_classify u_classify (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .win_valid_i (win_valid),
    .win_i       (win),
    .cfg_i       (cfg_q),
    .win_ready_o (win_ready),
    .out_o       (out_o)
  );

endmodule

// ----- verif/tb_hyphen_break_classifier_top.sv -----
// ----------------------------------------------------------------------------
// tb_hyphen_break_classifier_top
// Self-checking bench: streams words of codepoints through the classifier,
// predicts the break kind and position of each character from a local copy
// of the character window and the registers, and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_hyphen_break_classifier_top;
  import hbc_pkg::*;

  // position saturates at the smaller of 255 and the longest word
  localparam int unsigned POS_CAP =
    (HBC_MAX_WORD_LEN_DEF < 255) ? HBC_MAX_WORD_LEN_DEF : 255;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned LONG_HOLD   = 200;
  localparam int unsigned DRAIN_WAIT  = 4;
  localparam int unsigned MAX_REPORTS = 40;

  // locale codes with no meaning of their own, classed as other
  localparam logic [LOC_W-1:0] LOC_SPARE_LO = 3'd5;
  localparam logic [LOC_W-1:0] LOC_SPARE_HI = 3'd7;

  typedef struct {
    logic [CP_W-1:0]  cp;
    logic             start;
    logic [LEN_W-1:0] len;
  } char_item_t;

  typedef struct {
    break_kind_e      kind;
    logic [POS_W-1:0] pos;
  } break_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  hbc_in_if  in_bus ();
  hbc_out_if out_bus ();

  hyphen_break_classifier_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  // characters waiting to be sent, and breaks waiting to come out
  char_item_t    char_pending_q[$];
  break_result_t break_expect_q[$];

  // local copy of the registers and the character window
  logic [LOC_W-1:0] locale_q;
  logic [MIN_W-1:0] prefix_q;
  logic [MIN_W-1:0] suffix_q;
  logic [CP_W-1:0]  hist1_q;
  logic [CP_W-1:0]  hist2_q;
  logic [POS_W-1:0] word_pos_q;

  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int unsigned rx_hold_left;
  bit          offer_open;

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // break prediction
  // ---------------------------------------------------------------------------
  function automatic bit splits_after(logic [CP_W-1:0] c);
    case (c)
      CP_HYPHEN_MINUS, 21'h00058A, 21'h0005BE, 21'h001400, CP_HYPHEN,
      21'h002013, 21'h002027, 21'h002E17, 21'h002E40: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit latin_letter(logic [CP_W-1:0] c);
    return (c >= 21'h41 && c <= 21'h5A) || (c >= 21'h61 && c <= 21'h7A) ||
           (c >= 21'hC0 && c <= 21'h24F);
  endfunction

  function automatic bit arabic_letter(logic [CP_W-1:0] c);
    return (c >= 21'h600 && c <= 21'h6FF) || (c >= 21'h750 && c <= 21'h77F);
  endfunction

  function automatic bit dravidian_letter(logic [CP_W-1:0] c);
    return (c >= 21'hC00 && c <= 21'hD7F) || (c >= 21'hB80 && c <= 21'hBFF);
  endfunction

  function automatic break_kind_e break_kind_at(int unsigned i, logic [CP_W-1:0] cur,
                                                int unsigned len);
    if (i == 0) return KIND_NONE;
    // explicit hyphen one place back
    if (i > 1 && splits_after(hist1_q)) begin
      if ((hist1_q == CP_HYPHEN_MINUS || hist1_q == CP_HYPHEN) &&
          (locale_q == LOC_POLISH || locale_q == LOC_SLOVENIAN) &&
          i < len && latin_letter(cur))
        return KIND_INSERT_NEXT;
      return KIND_NO_INSERT;
    end
    // soft hyphen, kind chosen by script of the current character
    if (i > 1 && hist1_q == CP_SOFT_HYPHEN) begin
      if (arabic_letter(cur)) return KIND_INSERT_NEXT;
      if (dravidian_letter(cur)) return KIND_NO_INSERT;
      return KIND_BREAK;
    end
    // catalan l middle-dot l
    if (hist1_q == CP_MIDDLE_DOT && i > 1 && prefix_q < i && i + suffix_q <= len &&
        locale_q == LOC_CATALAN &&
        ((hist2_q == CP_LOWER_L && cur == CP_LOWER_L) ||
         (hist2_q == CP_UPPER_L && cur == CP_UPPER_L)))
      return KIND_REPLACE;
    return KIND_NONE;
  endfunction

  task automatic predict_char(input char_item_t it);
    break_result_t res;
    if (it.start) begin
      word_pos_q = '0;
      hist2_q    = '0;
    end
    res.kind = break_kind_at(32'(word_pos_q), it.cp, 32'(it.len));
    res.pos  = word_pos_q;
    break_expect_q = {break_expect_q, res};
    hist2_q = it.start ? '0 : hist1_q;
    hist1_q = it.cp;
    if (word_pos_q < POS_CAP) word_pos_q = word_pos_q + 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // input driver
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else if (offer_open) begin
      // transaction still on offer, hold it
    end else if (char_pending_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
      in_bus.valid       <= 1'b1;
      in_bus.codepoint   <= char_pending_q[0].cp;
      in_bus.word_start  <= char_pending_q[0].start;
      in_bus.word_length <= char_pending_q[0].len;
      offer_open = 1'b1;
    end else begin
      in_bus.valid <= 1'b0;
    end
  end

  // input monitor, feeds the predictor
  always @(posedge clk_i) begin
    char_item_t it;
    if (rst_ni && in_bus.valid && in_bus.ready) begin
      it.cp    = in_bus.codepoint;
      it.start = in_bus.word_start;
      it.len   = in_bus.word_length;
      predict_char(it);
      void'(char_pending_q.pop_front());
      offer_open = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // output side: ready with random stalls and a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    break_result_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (break_expect_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result kind %0d pos %0d",
                                out_bus.break_kind, out_bus.char_position));
      end else begin
        want = break_expect_q.pop_front();
        if (out_bus.break_kind !== want.kind)
          flag_mismatch($sformatf("break_kind %0d, want %0d at pos %0d",
                                  out_bus.break_kind, want.kind, want.pos));
        if (out_bus.char_position !== want.pos)
          flag_mismatch($sformatf("char_position %0d, want %0d",
                                  out_bus.char_position, want.pos));
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", quiet_cycles);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_char(input logic [CP_W-1:0] cp, input logic start,
                            input logic [LEN_W-1:0] len);
    char_item_t it;
    it.cp    = cp;
    it.start = start;
    it.len   = len;
    char_pending_q = {char_pending_q, it};
  endtask

  task automatic wait_drained();
    while (char_pending_q.size() != 0 || break_expect_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_LOCALE:     locale_q = val[LOC_W-1:0];
      CFG_MIN_PREFIX: prefix_q = val[MIN_W-1:0];
      CFG_MIN_SUFFIX: suffix_q = val[MIN_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // registers change only with the pipeline empty
  task automatic set_config(input logic [LOC_W-1:0] loc, input logic [MIN_W-1:0] pre,
                            input logic [MIN_W-1:0] suf);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    write_reg(CFG_LOCALE, {1'b0, loc});
    write_reg(CFG_MIN_PREFIX, pre);
    write_reg(CFG_MIN_SUFFIX, suf);
  endtask

  // codepoint mix weighted towards the characters the rules look at
  function automatic logic [CP_W-1:0] pick_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 18) return $urandom_range(1) ? CP_LOWER_L : CP_UPPER_L;
    if (r < 28) return CP_MIDDLE_DOT;
    if (r < 36) return CP_SOFT_HYPHEN;
    if (r < 43) return $urandom_range(1) ? CP_HYPHEN_MINUS : CP_HYPHEN;
    if (r < 48) begin
      case ($urandom_range(6))
        0: return 21'h00058A;
        1: return 21'h0005BE;
        2: return 21'h001400;
        3: return 21'h002013;
        4: return 21'h002027;
        5: return 21'h002E17;
        default: return 21'h002E40;
      endcase
    end
    if (r < 54) return $urandom_range(1) ? CP_W'($urandom_range(21'h6FF, 21'h600))
                                         : CP_W'($urandom_range(21'h77F, 21'h750));
    if (r < 60) return $urandom_range(1) ? CP_W'($urandom_range(21'hBFF, 21'hB80))
                                         : CP_W'($urandom_range(21'hD7F, 21'hC00));
    if (r < 78) begin
      case ($urandom_range(2))
        0: return CP_W'($urandom_range(21'h7A, 21'h61));
        1: return CP_W'($urandom_range(21'h5A, 21'h41));
        default: return CP_W'($urandom_range(21'h24F, 21'hC0));
      endcase
    end
    // script range edges
    if (r < 88) begin
      case ($urandom_range(13))
        0: return 21'h40;
        1: return 21'h5B;
        2: return 21'h60;
        3: return 21'h7B;
        4: return 21'hBF;
        5: return 21'h250;
        6: return 21'h5FF;
        7: return 21'h700;
        8: return 21'h74F;
        9: return 21'h780;
        10: return 21'hB7F;
        11: return 21'hC00;
        12: return 21'hD80;
        default: return 21'hBFF;
      endcase
    end
    if (r < 95) return CP_W'($urandom_range(21'h3000));
    return CP_W'($urandom_range(21'h1FFFFF));
  endfunction

  // one word of random text, often with a rule pattern planted in it
  task automatic queue_word(input int unsigned n, input logic [LEN_W-1:0] len,
                            input bit start);
    logic [CP_W-1:0] w[$];
    logic [CP_W-1:0] c;
    int unsigned     k;
    for (int unsigned i = 0; i < n; i++) w = {w, pick_char()};
    if (n >= 3 && $urandom_range(1)) begin
      k = $urandom_range(n - 3);
      case ($urandom_range(2))
        0: begin
          c = $urandom_range(1) ? CP_LOWER_L : CP_UPPER_L;
          w[k]     = c;
          w[k + 1] = CP_MIDDLE_DOT;
          w[k + 2] = c;
        end
        1: begin
          w[k + 1] = $urandom_range(1) ? CP_HYPHEN_MINUS : CP_HYPHEN;
          w[k + 2] = CP_W'($urandom_range(21'h7A, 21'h61));
        end
        default: begin
          w[k + 1] = CP_SOFT_HYPHEN;
          w[k + 2] = pick_char();
        end
      endcase
    end
    for (int unsigned i = 0; i < n; i++) queue_char(w[i], start && i == 0, len);
  endtask

  // mostly well-formed words, some without a start mark, some noise
  task automatic queue_text(input int unsigned n_items);
    int unsigned done;
    int unsigned n;
    int unsigned r;
    logic [LEN_W-1:0] len;
    done = 0;
    while (done < n_items) begin
      r = $urandom_range(99);
      if (r < 85) begin
        n   = ($urandom_range(9) < 7) ? $urandom_range(10, 1) : $urandom_range(24, 11);
        len = ($urandom_range(19) == 0) ? LEN_W'($urandom_range(255)) : LEN_W'(n);
        queue_word(n, len, 1'b1);
      end else if (r < 95) begin
        n = $urandom_range(8, 1);
        queue_word(n, LEN_W'($urandom_range(255)), 1'b0);
      end else begin
        n = 1;
        queue_char(CP_W'($urandom_range(21'h1FFFFF)), 1'($urandom_range(1)),
                   LEN_W'($urandom_range(255)));
      end
      done += n;
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = CFG_LOCALE;
    cfg_data_i            = '0;
    in_bus.valid          = 1'b0;
    in_bus.codepoint      = '0;
    in_bus.word_start     = 1'b0;
    in_bus.word_length    = '0;
    out_bus.ready         = 1'b0;
    locale_q              = LOC_OTHER;
    prefix_q              = 4'd2;
    suffix_q              = 4'd2;
    hist1_q               = '0;
    hist2_q               = '0;
    word_pos_q            = '0;
    mismatches            = 0;
    quiet_cycles          = 0;
    tx_idle_pct           = 0;
    rx_stall_pct          = 0;
    rx_hold_left          = 0;
    offer_open            = 1'b0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: missing start mark, hyphen, soft hyphen by script
    queue_char(21'h61, 1'b0, 8'd5);
    queue_char(CP_HYPHEN_MINUS, 1'b0, 8'd5);
    queue_char(21'h1FFFFF, 1'b0, 8'd255);
    queue_char(CP_SOFT_HYPHEN, 1'b1, 8'd0);
    queue_char(21'h62, 1'b0, 8'd6);
    queue_char(CP_SOFT_HYPHEN, 1'b0, 8'd6);
    queue_char(21'h627, 1'b0, 8'd6);
    queue_char(CP_SOFT_HYPHEN, 1'b0, 8'd6);
    queue_char(21'hC15, 1'b0, 8'd6);
    queue_char(CP_SOFT_HYPHEN, 1'b0, 8'd6);
    queue_char(21'h41, 1'b0, 8'd6);
    queue_char(21'h0, 1'b1, 8'd1);

    // polish: insert-and-next, then the length test failing
    set_config(LOC_POLISH, 4'd2, 4'd2);
    queue_char(21'h61, 1'b1, 8'd4);
    queue_char(CP_HYPHEN, 1'b0, 8'd4);
    queue_char(21'h7A, 1'b0, 8'd4);
    queue_char(CP_HYPHEN_MINUS, 1'b0, 8'd4);
    queue_char(21'h62, 1'b0, 8'd4);

    // catalan with zero prefix: l.l and L.L
    set_config(LOC_CATALAN, 4'd0, 4'd1);
    queue_char(CP_LOWER_L, 1'b1, 8'd4);
    queue_char(CP_MIDDLE_DOT, 1'b0, 8'd4);
    queue_char(CP_LOWER_L, 1'b0, 8'd4);
    queue_char(CP_UPPER_L, 1'b0, 8'd9);
    queue_char(CP_MIDDLE_DOT, 1'b0, 8'd9);
    queue_char(CP_UPPER_L, 1'b0, 8'd9);

    // random text over several register settings and idling patterns
    for (int unsigned p = 0; p < 8; p++) begin
      case (p)
        0: set_config(LOC_CATALAN, 4'd1, 4'd1);
        1: set_config(LOC_SLOVENIAN, 4'd8, 4'd8);
        2: set_config(LOC_CATALAN, 4'd15, 4'd0);
        3: set_config(LOC_SPARE_HI, 4'd0, 4'd15);
        4: set_config(LOC_PORTUGUESE, 4'd2, 4'd2);
        5: set_config(LOC_POLISH, 4'd8, 4'd1);
        6: set_config(LOC_SPARE_LO, 4'd4, 4'd3);
        default: set_config(LOC_CATALAN, 4'd0, 4'd8);
      endcase
      case (p % 4)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 70;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 70;
        end
        default: begin
          tx_idle_pct  = 8;
          rx_stall_pct = 8;
        end
      endcase
      queue_text(100);
      // one over-long word so the position saturates
      if (p == 3) queue_word(300, 8'd255, 1'b1);
      // receiver holds off while the sender keeps offering
      if (p == 0) rx_hold_left = LONG_HOLD;
    end

    wait_drained();
    repeat (DRAIN_WAIT * 2) @(posedge clk_i);
    if (break_expect_q.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", break_expect_q.size()));
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/hbc_pkg.sv
hdl/hbc_in_if.sv
hdl/hbc_out_if.sv
hdl/hbc_window.sv
hdl/hbc_classify.sv
hdl/hyphen_break_classifier_top.sv
verif/tb_hyphen_break_classifier_top.sv
